>>> rtl/core/gpioew_pkg.sv
// ----------------------------------------------------------------------------
// gpioew_pkg
// Shared types, constants and the pin level helper for the edge watcher core.
// ----------------------------------------------------------------------------
package gpioew_pkg;

    // table depth default and number of real ports in a snapshot
    localparam int SLOTS_DEF = 16;
    localparam int PORTS     = 5;

    // field widths
    localparam int OP_W     = 2;
    localparam int PIN_W    = 11;
    localparam int LEVELS_W = 40;
    localparam int TIME_W   = 32;
    localparam int NUM_W    = 32;

    // packed beat widths, rounded up to whole bytes
    localparam int IN_RAW_W  = OP_W + PIN_W + LEVELS_W + TIME_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = PIN_W + 1 + TIME_W + NUM_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WATCH   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNWATCH = 2'd2;

    // broadcast control from the scan controller to every cell
    typedef struct packed {
        logic             start;
        logic             advance;
        logic             claim;
        logic             clear;
        logic             upd;
        logic             commit;
        logic [PIN_W-1:0] code;
        logic             level;
    } ctl_t;

    // contents of the cell holding the scan token, zero elsewhere
    typedef struct packed {
        logic             valid;
        logic [PIN_W-1:0] pin;
        logic             level;
    } view_t;

    // level of one pin: port byte masked, any bit set reads high
    function automatic logic level_of(input logic [LEVELS_W-1:0] levels,
                                      input logic [PIN_W-1:0]    code);
        logic [LEVELS_W-1:0] sh;
        logic                in_range;
        sh       = levels >> {code[10:8], 3'b000};
        in_range = ({1'b0, code[10:8]} < 4'(PORTS));
        return in_range && (|(sh[7:0] & code[7:0]));
    endfunction

endpackage

>>> rtl/core/gpio_multi_pin_edge_watcher_core.sv
// ----------------------------------------------------------------------------
// gpio_multi_pin_edge_watcher_core
// Watches up to SLOTS pins over five port bytes and reports level changes
// with a timestamp and a running sequence number.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents (low bits first)
//  --------+-----+----------------------------------------------------------
//  s_*     | in  | op, pin_code, port_levels, time_ms
//  m_*     | out | edge_pin, edge_level, edge_time, edge_number; run_last on tlast
//
//  A scan token walks the row of slot cells, one cell per cycle unless paused;
//  unwatch and undefined ops return to idle when the scan ends; watch passes
//  through a commit state and sample through a final-edge flush state first.
//  The scan pauses only on an edge found while another edge is pending and the
//  output register holds an untaken beat; the flush likewise waits for m_tready.
//  Reset empties the table and zeroes the sequence number; no clearing pass.
//
module gpio_multi_pin_edge_watcher_core
#(
    parameter int SLOTS = gpioew_pkg::SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gpioew_pkg::IN_W-1:0]   s_tdata,   // op, pin_code, port_levels, time_ms
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gpioew_pkg::OUT_W-1:0]  m_tdata,   // edge_pin, edge_level, edge_time, edge_number
    output logic                          m_tlast
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT, ST_FLUSH} state_t;

    state_t                            state_reg;
    state_t                            state_next;

    // held item
    logic [gpioew_pkg::OP_W-1:0]       op_reg;
    logic [gpioew_pkg::PIN_W-1:0]      code_reg;
    logic [gpioew_pkg::LEVELS_W-1:0]   levels_reg;
    logic [gpioew_pkg::TIME_W-1:0]     time_reg;

    // scan flags
    logic                              dup_reg;
    logic                              dup_next;
    logic                              found_reg;
    logic                              found_next;

    // edge waiting until we know whether it closes the run
    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    logic [gpioew_pkg::PIN_W-1:0]      pend_pin_reg;
    logic                              pend_level_reg;

    // output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [gpioew_pkg::PIN_W-1:0]      out_pin_reg;
    logic                              out_level_reg;
    logic [gpioew_pkg::TIME_W-1:0]     out_time_reg;
    logic [gpioew_pkg::NUM_W-1:0]      out_number_reg;
    logic                              out_last_reg;
    logic [gpioew_pkg::NUM_W-1:0]      seq_reg;
    logic [gpioew_pkg::NUM_W-1:0]      seq_next;

    gpioew_pkg::ctl_t                  ctl;
    gpioew_pkg::view_t                 view_arr [SLOTS];
    gpioew_pkg::view_t                 view_all;
    logic [SLOTS-1:0]                  tokens;

    logic                              accept;
    logic                              sample_level;
    logic                              watch_level;
    logic                              change;
    logic                              blocked;
    logic                              advance;
    logic                              match;
    logic                              scan_done;
    logic                              push;

    // row of slot cells with the token handed down the chain
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic tok_in;
        if (i == 0)
        begin : g_head
            assign tok_in = ctl.start;
        end
        else
        begin : g_link
            assign tok_in = tokens[i-1];
        end

        gpioew_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .token_in  (tok_in),
            .token_out (tokens[i]),
            .view      (view_arr[i])
        );
    end

    // token holder contents
    always_comb
    begin
        view_all = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            view_all = view_all | view_arr[i];
        end
    end

    // scan step decisions
    always_comb
    begin
        accept       = (state_reg == ST_IDLE) && s_tvalid;
        sample_level = gpioew_pkg::level_of(levels_reg, view_all.pin);
        watch_level  = gpioew_pkg::level_of(levels_reg, code_reg);
        change       = (state_reg == ST_SCAN) && (op_reg == gpioew_pkg::OP_SAMPLE) &&
                       view_all.valid && (sample_level != view_all.level);
        blocked      = out_valid_reg && !m_tready;
        advance      = (state_reg == ST_SCAN) && !(change && pend_valid_reg && blocked);
        match        = view_all.valid && (view_all.pin == code_reg);
        scan_done    = advance && tokens[SLOTS-1];
        push         = pend_valid_reg && !blocked &&
                       (((state_reg == ST_SCAN) && change) || (state_reg == ST_FLUSH));

        ctl.start    = accept;
        ctl.advance  = advance;
        ctl.claim    = advance && (op_reg == gpioew_pkg::OP_WATCH) &&
                       !view_all.valid && !found_reg;
        ctl.clear    = advance && (op_reg == gpioew_pkg::OP_UNWATCH) && match;
        ctl.upd      = advance && change;
        ctl.commit   = (state_reg == ST_COMMIT) && found_reg && !dup_reg;
        ctl.code     = code_reg;
        ctl.level    = (state_reg == ST_COMMIT) ? watch_level : sample_level;
    end

    // sequencer and control next state
    always_comb
    begin
        state_next      = state_reg;
        dup_next        = dup_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        seq_next        = seq_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    dup_next   = 1'b0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (advance && (op_reg == gpioew_pkg::OP_WATCH) && match)
                begin
                    dup_next = 1'b1;
                end
                if (ctl.claim)
                begin
                    found_next = 1'b1;
                end
                if (ctl.upd)
                begin
                    pend_valid_next = 1'b1;
                end
                if (scan_done)
                begin
                    case (op_reg)
                        gpioew_pkg::OP_WATCH:  state_next = ST_COMMIT;
                        gpioew_pkg::OP_SAMPLE: state_next = ST_FLUSH;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || push)
                begin
                    state_next      = ST_IDLE;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register load and drain
        if (push)
        begin
            out_valid_next = 1'b1;
            seq_next       = seq_reg + 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dup_reg        <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            seq_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dup_reg        <= dup_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            seq_reg        <= seq_next;
        end
    end

    // payload flops
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tdata[1:0];
            code_reg   <= s_tdata[12:2];
            levels_reg <= s_tdata[52:13];
            time_reg   <= s_tdata[84:53];
        end
        if (push)
        begin
            out_pin_reg    <= pend_pin_reg;
            out_level_reg  <= pend_level_reg;
            out_time_reg   <= time_reg;
            out_number_reg <= seq_reg;
            out_last_reg   <= (state_reg == ST_FLUSH);
        end
        if (ctl.upd)
        begin
            pend_pin_reg   <= view_all.pin;
            pend_level_reg <= sample_level;
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(gpioew_pkg::OUT_W - gpioew_pkg::OUT_RAW_W){1'b0}},
                       out_number_reg, out_time_reg, out_level_reg, out_pin_reg};

endmodule

>>> rtl/core/gpioew_cell.sv
// ----------------------------------------------------------------------------
// gpioew_cell
// One table slot: pin code, valid mark, last level and the scan token.
// ----------------------------------------------------------------------------
module gpioew_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  gpioew_pkg::ctl_t    ctl,
    input  logic                token_in,
    output logic                token_out,
    output gpioew_pkg::view_t   view
);

    logic                         token_reg;
    logic                         token_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         chosen_reg;
    logic                         chosen_next;
    logic [gpioew_pkg::PIN_W-1:0] pin_reg;
    logic [gpioew_pkg::PIN_W-1:0] pin_next;
    logic                         level_reg;
    logic                         level_next;

    // next state of the slot
    always_comb
    begin
        token_next  = (ctl.start || ctl.advance) ? token_in : token_reg;
        chosen_next = chosen_reg;
        valid_next  = valid_reg;
        pin_next    = pin_reg;
        level_next  = level_reg;

        // first free slot seen by a watch scan is marked for the commit
        if (ctl.start)
        begin
            chosen_next = 1'b0;
        end
        else if (ctl.claim && token_reg)
        begin
            chosen_next = 1'b1;
        end

        if (ctl.commit && chosen_reg)
        begin
            valid_next = 1'b1;
            pin_next   = ctl.code;
            level_next = ctl.level;
        end

        if (ctl.clear && token_reg)
        begin
            valid_next = 1'b0;
        end

        if (ctl.upd && token_reg)
        begin
            level_next = ctl.level;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            chosen_reg <= 1'b0;
        end
        else
        begin
            token_reg  <= token_next;
            valid_reg  <= valid_next;
            chosen_reg <= chosen_next;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        pin_reg   <= pin_next;
        level_reg <= level_next;
    end

    // only the token holder shows its contents
    always_comb
    begin
        view = '0;
        if (token_reg)
        begin
            view.valid = valid_reg;
            view.pin   = pin_reg;
            view.level = level_reg;
        end
    end

    assign token_out = token_reg;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-pin edge watcher core. A directed script
// walks the special cases of the slot table, then random beats of all four
// op codes follow. Every accepted input beat runs through a local model
// of the table; each output beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // field widths taken from the package
    localparam int OP_W     = gpioew_pkg::OP_W;
    localparam int PIN_W    = gpioew_pkg::PIN_W;
    localparam int LEVELS_W = gpioew_pkg::LEVELS_W;
    localparam int TIME_W   = gpioew_pkg::TIME_W;
    localparam int NUM_W    = gpioew_pkg::NUM_W;

    // beat layout, low bits first
    localparam int PIN_LO    = OP_W;
    localparam int LEV_LO    = PIN_LO + PIN_W;
    localparam int STAMP_LO  = LEV_LO + LEVELS_W;
    localparam int LEVEL_BIT = PIN_W;
    localparam int ETIME_LO  = PIN_W + 1;
    localparam int ENUM_LO   = ETIME_LO + TIME_W;

    localparam int TABLE_SLOTS  = gpioew_pkg::SLOTS_DEF;
    localparam int RANDOM_ITEMS = 102;
    localparam int POOL_SIZE    = 24;
    localparam int LIMIT_CYCLES = 400000;

    // op code the block has to ignore
    localparam logic [OP_W-1:0]     OP_UNDEF = 2'd3;
    localparam logic [LEVELS_W-1:0] ALL_HIGH = '1;
    localparam logic [LEVELS_W-1:0] ALL_LOW  = '0;

    typedef struct packed {
        logic [PIN_W-1:0]  pin;
        logic              level;
        logic [TIME_W-1:0] stamp;
        logic [NUM_W-1:0]  number;
        logic              last;
    } capture_t;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [PIN_W-1:0]    pin;
        logic [LEVELS_W-1:0] levels;
        logic [TIME_W-1:0]   stamp;
        bit                  typed;
        bit                  has_edge;
        capture_t            want_edge;
    } row_t;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [gpioew_pkg::IN_W-1:0] s_tdata  = '0;   // op, pin_code, port_levels, time_ms
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [gpioew_pkg::OUT_W-1:0] m_tdata;        // edge_pin, edge_level, edge_time, edge_number
    logic            m_tlast;

    // expectation of the beat being offered, for script rows typed by hand
    bit       cur_typed    = 1'b0;
    bit       cur_has_edge = 1'b0;
    capture_t cur_want     = '0;

    // model copy of the watch table
    logic [PIN_W-1:0] tbl_pin   [TABLE_SLOTS];
    logic             tbl_valid [TABLE_SLOTS];
    logic             tbl_level [TABLE_SLOTS];
    logic [NUM_W-1:0] seq_count;

    capture_t pending_edges[$];
    capture_t new_edges[$];
    row_t     script[$];

    logic [PIN_W-1:0]    pin_pool [POOL_SIZE];
    logic [LEVELS_W-1:0] last_snapshot = '0;
    int                  fail_count    = 0;
    int                  cycle_count   = 0;
    int                  calm_items    = 0;
    int                  sink_stall    = 0;
    int                  sink_steady   = 0;
    int                  sink_roll;

    gpio_multi_pin_edge_watcher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // level of a pin in a snapshot, ports past the last one read low
    function automatic logic pin_level(input logic [LEVELS_W-1:0] levels,
                                       input logic [PIN_W-1:0] code);
        logic [LEVELS_W-1:0] shifted;
        int                  port;
        port    = int'(code[10:8]);
        shifted = levels >> (8 * port);
        if (port >= gpioew_pkg::PORTS)
            return 1'b0;
        return |(shifted[7:0] & code[7:0]);
    endfunction

    // table update for one accepted beat, edges land in new_edges
    task automatic predict_edges(input logic [OP_W-1:0] op,
                                 input logic [PIN_W-1:0] code,
                                 input logic [LEVELS_W-1:0] levels,
                                 input logic [TIME_W-1:0] stamp);
        int       free_slot;
        bit       hit;
        logic     lv;
        capture_t cap;
        new_edges.delete();
        free_slot = -1;
        hit       = 1'b0;
        case (op)
            gpioew_pkg::OP_WATCH:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (tbl_valid[i] && tbl_pin[i] == code)
                        hit = 1'b1;
                    if (free_slot < 0 && !tbl_valid[i])
                        free_slot = i;
                end
                if (!hit && free_slot >= 0)
                begin
                    tbl_pin[free_slot]   = code;
                    tbl_valid[free_slot] = 1'b1;
                    tbl_level[free_slot] = pin_level(levels, code);
                end
            end
            gpioew_pkg::OP_UNWATCH:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (!hit && tbl_valid[i] && tbl_pin[i] == code)
                    begin
                        tbl_valid[i] = 1'b0;
                        hit          = 1'b1;
                    end
                end
            end
            gpioew_pkg::OP_SAMPLE:
            begin
                // scan in slot order, one edge per changed slot
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        lv = pin_level(levels, tbl_pin[i]);
                        if (lv != tbl_level[i])
                        begin
                            tbl_level[i] = lv;
                            cap = '{pin: tbl_pin[i], level: lv, stamp: stamp,
                                    number: seq_count, last: 1'b0};
                            new_edges.push_back(cap);
                            seq_count = seq_count + 1;
                        end
                    end
                end
                if (new_edges.size() > 0)
                begin
                    cap      = new_edges.pop_back();
                    cap.last = 1'b1;
                    new_edges.push_back(cap);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    function automatic row_t plain_row(input logic [OP_W-1:0] op,
                                       input logic [PIN_W-1:0] pin,
                                       input logic [LEVELS_W-1:0] levels,
                                       input logic [TIME_W-1:0] stamp);
        row_t r;
        r.op        = op;
        r.pin       = pin;
        r.levels    = levels;
        r.stamp     = stamp;
        r.typed     = 1'b0;
        r.has_edge  = 1'b0;
        r.want_edge = '0;
        return r;
    endfunction

    function automatic row_t typed_row(input logic [OP_W-1:0] op,
                                       input logic [LEVELS_W-1:0] levels,
                                       input logic [TIME_W-1:0] stamp,
                                       input bit has_edge, input capture_t want);
        row_t r;
        r           = plain_row(op, '0, levels, stamp);
        r.typed     = 1'b1;
        r.has_edge  = has_edge;
        r.want_edge = want;
        return r;
    endfunction

    // random beat: mostly pins from a small pool so watches and unwatches meet
    function automatic row_t random_row();
        int                  roll;
        logic [OP_W-1:0]     op;
        logic [PIN_W-1:0]    pin;
        logic [63:0]         wide;
        logic [LEVELS_W-1:0] levels;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            op = gpioew_pkg::OP_SAMPLE;
        else if (roll < 75)
            op = gpioew_pkg::OP_WATCH;
        else if (roll < 93)
            op = gpioew_pkg::OP_UNWATCH;
        else
            op = OP_UNDEF;
        if ($urandom_range(0, 99) < 85)
            pin = pin_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            pin = PIN_W'($urandom);
        roll = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (roll < 5)
            levels = ALL_HIGH;
        else if (roll < 10)
            levels = ALL_LOW;
        else if (roll < 50)
            levels = wide[LEVELS_W-1:0];
        else
        begin
            // small change from the last snapshot
            levels = last_snapshot ^ (LEVELS_W'(1) << $urandom_range(0, LEVELS_W - 1));
            if ($urandom_range(0, 1) == 1)
                levels = levels ^ (LEVELS_W'(1) << $urandom_range(0, LEVELS_W - 1));
        end
        last_snapshot = levels;
        return plain_row(op, pin, levels, $urandom);
    endfunction

    // input idle length, with calm stretches of back-to-back beats
    function automatic int next_gap();
        int roll;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            calm_items = $urandom_range(8, 20);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_row(input row_t r);
        logic [gpioew_pkg::IN_W-1:0] d;
        d = '0;
        d[PIN_LO-1:0]         = r.op;
        d[LEV_LO-1:PIN_LO]    = r.pin;
        d[STAMP_LO-1:LEV_LO]  = r.levels;
        d[STAMP_LO+TIME_W-1:STAMP_LO] = r.stamp;
        s_tdata      <= d;
        s_tvalid     <= 1'b1;
        cur_typed    <= r.typed;
        cur_has_edge <= r.has_edge;
        cur_want     <= r.want_edge;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic play_row(input row_t r);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_row(r);
    endtask

    // output ready with short and long stalls and steady stretches
    always @(posedge clk)
    begin
        if (sink_stall != 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (sink_steady != 0)
                sink_steady <= sink_steady - 1;
            else
            begin
                sink_roll = $urandom_range(0, 99);
                if (sink_roll < 4)
                    sink_steady <= $urandom_range(20, 60);
                else if (sink_roll < 30)
                    sink_stall <= $urandom_range(1, 3);
                else if (sink_roll < 34)
                    sink_stall <= $urandom_range(10, 40);
            end
        end
    end

    // check output beats, then predict from accepted input beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_edges.size() == 0)
                begin
                    $display("%0t: unexpected edge, expected none, actual pin %h number %h",
                             $time, m_tdata[PIN_W-1:0], m_tdata[ENUM_LO+NUM_W-1:ENUM_LO]);
                    fail_count++;
                end
                else
                begin
                    compare_field("edge_pin", 32'(pending_edges[0].pin),
                                  32'(m_tdata[PIN_W-1:0]));
                    compare_field("edge_level", 32'(pending_edges[0].level),
                                  32'(m_tdata[LEVEL_BIT]));
                    compare_field("edge_time", pending_edges[0].stamp,
                                  m_tdata[ETIME_LO+TIME_W-1:ETIME_LO]);
                    compare_field("edge_number", pending_edges[0].number,
                                  m_tdata[ENUM_LO+NUM_W-1:ENUM_LO]);
                    compare_field("run_last", 32'(pending_edges[0].last), 32'(m_tlast));
                    void'(pending_edges.pop_front());
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_edges(s_tdata[PIN_LO-1:0], s_tdata[LEV_LO-1:PIN_LO],
                              s_tdata[STAMP_LO-1:LEV_LO],
                              s_tdata[STAMP_LO+TIME_W-1:STAMP_LO]);
                if (cur_typed)
                begin
                    if (cur_has_edge)
                        pending_edges.push_back(cur_want);
                end
                else
                begin
                    foreach (new_edges[i])
                        pending_edges.push_back(new_edges[i]);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_pin[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_level[i] = 1'b0;
        end
        seq_count = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            pin_pool[i] = PIN_W'($urandom);

        // directed script
        script.push_back(typed_row(gpioew_pkg::OP_SAMPLE, ALL_HIGH, 32'h1234_5678, 1'b0, '0));
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h0FF, ALL_LOW, 32'd1));
        script.push_back(typed_row(gpioew_pkg::OP_SAMPLE, 40'hFF, 32'd0, 1'b1,
                         '{pin: 11'h0FF, level: 1'b1, stamp: 32'd0, number: 32'd0,
                           last: 1'b1}));
        // port out of range and zero mask both read low
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h7FF, ALL_HIGH, 32'd2));
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h100, ALL_HIGH, 32'd3));
        // pin already watched
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h0FF, ALL_LOW, 32'd4));
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h480, ALL_LOW, 32'd5));
        script.push_back(typed_row(gpioew_pkg::OP_SAMPLE, ALL_HIGH, 32'hFFFF_FFFF, 1'b1,
                         '{pin: 11'h480, level: 1'b1, stamp: 32'hFFFF_FFFF,
                           number: 32'd1, last: 1'b1}));
        script.push_back(plain_row(gpioew_pkg::OP_SAMPLE, 11'h000, ALL_LOW, 32'd6));
        // unwatch of a pin not watched, undefined op
        script.push_back(plain_row(gpioew_pkg::OP_UNWATCH, 11'h123, ALL_LOW, 32'd7));
        script.push_back(plain_row(OP_UNDEF, 11'h7FF, ALL_HIGH, 32'hFFFF_FFFF));
        script.push_back(plain_row(gpioew_pkg::OP_UNWATCH, 11'h0FF, ALL_LOW, 32'd8));
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h201, 40'h00_0001_0000, 32'd9));
        // fill the table, last one on the first port past the end
        for (int i = 0; i < 11; i++)
            script.push_back(plain_row(gpioew_pkg::OP_WATCH,
                                       {3'(i % 5), 8'(1 << (i % 8))},
                                       ALL_LOW, 32'(10 + i)));
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h5FF, ALL_LOW, 32'd21));
        // table full
        script.push_back(plain_row(gpioew_pkg::OP_WATCH, 11'h3FF, ALL_HIGH, 32'd22));
        script.push_back(plain_row(gpioew_pkg::OP_SAMPLE, 11'h000, ALL_HIGH, 32'hA5A5_0000));
        script.push_back(plain_row(gpioew_pkg::OP_UNWATCH, 11'h3FF, ALL_HIGH, 32'd23));

        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            play_row(script[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            play_row(random_row());

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (3 * (TABLE_SLOTS + 2)) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> gpio_multi_pin_edge_watcher_core.f
rtl/core/gpioew_pkg.sv
rtl/core/gpioew_cell.sv
rtl/core/gpio_multi_pin_edge_watcher_core.sv
tb/testbench.sv
